FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked only outside reset
`define CTD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ctd check failed");
// property checked on every edge
`define CTD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ctd check failed");
`else
`define CTD_ASSERT(lbl, clk, rstn, prop)
`define CTD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/ctd_pkg.sv
package ctd_pkg;

    localparam int DEF_BLOCKS         = 4;
    localparam int DEF_CELLS_PER_SIDE = 8;
    localparam int DEF_GHOST          = 2;

    localparam int NCOMP = 13;

    localparam logic [1:0] REQ_DEPOSIT = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    localparam logic REG_MASS = 1'b0;
    localparam logic REG_ICV  = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [30:0] CFG_RESET = 31'd65536;

    localparam logic [3:0] COMP_LAST = 4'd12;

    // per-cell sequencer steps
    localparam logic [4:0] STEP_COEF   = 5'd0;
    localparam logic [4:0] STEP_SXY    = 5'd1;
    localparam logic [4:0] STEP_SZ     = 5'd2;
    localparam logic [4:0] STEP_CW     = 5'd3;
    localparam logic [4:0] STEP_T0     = 5'd4;
    localparam logic [4:0] STEP_T3     = 5'd7;
    localparam logic [4:0] STEP_TERM0  = 5'd8;
    localparam logic [4:0] STEP_TERM12 = 5'd20;
    localparam logic [4:0] STEP_WB     = 5'd21;

    typedef logic signed [31:0] t_word;
    typedef logic signed [32:0] t_mul_op;

    // first factor of a term: 0 is cw*u_dot_normal, 1..3 cw*vel
    function automatic logic [1:0] term_p(input logic [3:0] n);
        logic [1:0] p;
        p = 2'd0;
        case (n) inside
            4'd1, 4'd4, 4'd5, 4'd6:   p = 2'd1;
            4'd2, 4'd7, 4'd8, 4'd9:   p = 2'd2;
            4'd3, 4'd10, 4'd11, 4'd12: p = 2'd3;
            default:                  p = 2'd0;
        endcase
        return p;
    endfunction

    // second factor: 0 is u_dot_normal, 1..3 vel
    function automatic logic [1:0] term_q(input logic [3:0] n);
        logic [1:0] q;
        q = 2'd0;
        case (n) inside
            4'd4, 4'd7, 4'd10: q = 2'd1;
            4'd5, 4'd8, 4'd11: q = 2'd2;
            4'd6, 4'd9, 4'd12: q = 2'd3;
            default:           q = 2'd0;
        endcase
        return q;
    endfunction

endpackage

FILE: rtl/ctd_mul.sv
module ctd_mul (
    input  logic             i_clk,
    input  ctd_pkg::t_mul_op i_a,
    input  ctd_pkg::t_mul_op i_b,
    output logic signed [49:0] o_shr,
    output ctd_pkg::t_word   o_sat
);

    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // floor shift by 16, then clamp to the signed word range
    assign o_shr = 50'(r_prod >>> 16);

    always_comb begin
        if (!o_shr[49] && (o_shr[48:31] != '0)) begin
            o_sat = 32'sh7fffffff;
        end else if (o_shr[49] && (o_shr[48:31] != '1)) begin
            o_sat = 32'sh80000000;
        end else begin
            o_sat = o_shr[31:0];
        end
    end

endmodule

FILE: rtl/cic_tensor_deposit.sv
// cloud-in-cell tensor deposit engine
// input channel (i_in_valid / o_in_stall) carries one request item: deposit,
// read or clear of one cell in a 13-word-per-cell accumulator store.
// output channel (o_out_valid / i_out_stall) carries the 13 component items
// of a read, component 0 first, o_last on component 12.
// configuration (i_cfg_we, i_cfg_index, i_cfg_data) sets particle mass and
// inverse cell volume; write only while the block is idle.
// a deposit runs the 8 neighbor cells one after another: each cell reads its
// row from the store, walks 21 multiply steps on one shared 33x33
// multiplier, each step issuing a multiply and taking its registered
// product, then writes the row back; no new item is taken until the last
// cell is written back. a clear zeroes its cell's row; a read reads the
// row, registers it and loads its components into the output register.
// after reset the store is swept to zero, one cell row per cycle, over all
// BLOCKS*(CELLS_PER_SIDE+2*GHOST)^3 rows (6912 at default sizes); o_in_stall
// is high during the sweep. a stalled receiver holds the output item in its
// register; a read then waits and keeps o_in_stall high until its last
// component sits in the output register.
`include "assert_macros.svh"

module cic_tensor_deposit #(
    parameter int BLOCKS         = ctd_pkg::DEF_BLOCKS,
    parameter int CELLS_PER_SIDE = ctd_pkg::DEF_CELLS_PER_SIDE,
    parameter int GHOST          = ctd_pkg::DEF_GHOST
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [1:0]         i_block_index,
    input  logic signed [3:0]  i_cell_x,
    input  logic signed [3:0]  i_cell_y,
    input  logic signed [3:0]  i_cell_z,
    input  logic [16:0]        i_frac_x,
    input  logic [16:0]        i_frac_y,
    input  logic [16:0]        i_frac_z,
    input  logic signed [31:0] i_u_dot_normal,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_component,
    output logic signed [31:0] o_value,
    output logic               o_last,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [30:0]        i_cfg_data
);

    localparam int EXT   = CELLS_PER_SIDE + 2 * GHOST;
    localparam int CELLS = BLOCKS * EXT * EXT * EXT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(EXT) + 5;
    localparam int ROW_W = ctd_pkg::NCOMP * 32;
    localparam logic signed [CW-1:0] EXT_S = CW'(EXT);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DEP  = 3'd2;
    localparam logic [2:0] ST_RD0  = 3'd3;
    localparam logic [2:0] ST_RD1  = 3'd4;
    localparam logic [2:0] ST_RDO  = 3'd5;
    localparam logic [2:0] ST_CLC  = 3'd6;

    // control
    logic [2:0]    r_state;
    logic [AW-1:0] r_clr_addr;
    logic [2:0]    r_cell;      // {i,j,k} neighbor offset
    logic [4:0]    r_step;
    logic          r_ph;        // 0 issue multiply, 1 take product
    logic [3:0]    r_n;         // read component counter
    logic [30:0]   r_mass;
    logic [30:0]   r_icv;

    // request payload
    logic [1:0]           r_blk;
    logic                 r_blk_ok;
    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic [16:0]          r_fx, r_fy, r_fz;
    ctd_pkg::t_word       r_f [4];    // u_dot_normal, vel x/y/z

    // per-cell intermediates
    logic [30:0]    r_coef;
    logic [16:0]    r_m;
    logic [16:0]    r_w;
    logic [30:0]    r_cw;
    ctd_pkg::t_word r_t [4];
    ctd_pkg::t_word r_row [ctd_pkg::NCOMP];

    // output register
    logic           r_ovalid;
    logic [3:0]     r_ocomp;
    ctd_pkg::t_word r_oval;
    logic           r_olast;

    // store: one row of 13 words per cell
    logic [ROW_W-1:0] r_mem [CELLS];
    logic [ROW_W-1:0] r_rdata;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_addr;
    logic [ROW_W-1:0] mem_wdata;

    logic                 in_acc;
    logic signed [CW-1:0] cur_x, cur_y, cur_z;
    logic                 cell_ok;
    logic [AW-1:0]        cell_addr;
    logic [16:0]          s_x, s_y, s_z;
    logic [4:0]           rel_t, rel_n;
    logic [1:0]           t_idx;
    logic [3:0]           tn;
    ctd_pkg::t_mul_op     mul_a, mul_b;
    logic signed [49:0]   mul_shr;
    ctd_pkg::t_word       mul_sat;
    logic signed [33:0]   acc_sum;
    ctd_pkg::t_word       acc_sat;
    logic [2:0]           n_state;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // neighbor cell and its place in the store
    always_comb begin
        cur_x = r_cx + $signed({{(CW-1){1'b0}}, r_cell[2]});
        cur_y = r_cy + $signed({{(CW-1){1'b0}}, r_cell[1]});
        cur_z = r_cz + $signed({{(CW-1){1'b0}}, r_cell[0]});
        cell_ok = r_blk_ok
            && (cur_x >= 0) && (cur_x < EXT_S)
            && (cur_y >= 0) && (cur_y < EXT_S)
            && (cur_z >= 0) && (cur_z < EXT_S);
        cell_addr = AW'(AW'(r_blk) * AW'(EXT * EXT * EXT))
            + AW'(AW'(unsigned'(cur_z)) * AW'(EXT * EXT))
            + AW'(AW'(unsigned'(cur_y)) * AW'(EXT))
            + AW'(unsigned'(cur_x));
    end

    // trilinear shape factors: 1-frac on the left cell, frac on the right
    assign s_x = r_cell[2] ? r_fx : (ctd_pkg::ONE_Q16 - r_fx);
    assign s_y = r_cell[1] ? r_fy : (ctd_pkg::ONE_Q16 - r_fy);
    assign s_z = r_cell[0] ? r_fz : (ctd_pkg::ONE_Q16 - r_fz);

    assign rel_t = r_step - ctd_pkg::STEP_T0;
    assign rel_n = r_step - ctd_pkg::STEP_TERM0;
    assign t_idx = rel_t[1:0];
    assign tn    = rel_n[3:0];

    // multiplier operands per step
    always_comb begin
        case (r_step) inside
            ctd_pkg::STEP_COEF: begin
                mul_a = $signed({2'b00, r_mass});
                mul_b = $signed({2'b00, r_icv});
            end
            ctd_pkg::STEP_SXY: begin
                mul_a = $signed({16'd0, s_x});
                mul_b = $signed({16'd0, s_y});
            end
            ctd_pkg::STEP_SZ: begin
                mul_a = $signed({16'd0, r_m});
                mul_b = $signed({16'd0, s_z});
            end
            ctd_pkg::STEP_CW: begin
                mul_a = $signed({2'b00, r_coef});
                mul_b = $signed({16'd0, r_w});
            end
            [ctd_pkg::STEP_T0:ctd_pkg::STEP_T3]: begin
                mul_a = $signed({2'b00, r_cw});
                mul_b = 33'(r_f[t_idx]);
            end
            [ctd_pkg::STEP_TERM0:ctd_pkg::STEP_TERM12]: begin
                mul_a = 33'(r_t[ctd_pkg::term_p(tn)]);
                mul_b = 33'(r_f[ctd_pkg::term_q(tn)]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ctd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_shr (mul_shr),
        .o_sat (mul_sat)
    );

    // saturating accumulate, momentum terms go in negated
    always_comb begin
        if ((tn != 4'd0) && (tn < 4'd4)) begin
            acc_sum = 34'(r_row[tn]) - 34'(mul_sat);
        end else begin
            acc_sum = 34'(r_row[tn]) + 34'(mul_sat);
        end
        if (acc_sum > 34'sh07fffffff) begin
            acc_sat = 32'sh7fffffff;
        end else if (acc_sum < -34'sh080000000) begin
            acc_sat = 32'sh80000000;
        end else begin
            acc_sat = acc_sum[31:0];
        end
    end

    // store port use
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = cell_addr;
        mem_wdata = '0;
        case (r_state)
            ST_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_addr;
            end
            ST_CLC: mem_we = cell_ok;
            ST_RD0: mem_re = cell_ok;
            ST_DEP: begin
                if (r_step == ctd_pkg::STEP_WB) begin
                    mem_we = cell_ok;
                    for (int c = 0; c < ctd_pkg::NCOMP; c++) begin
                        mem_wdata[c*32 +: 32] = r_row[c];
                    end
                end else if (r_step == ctd_pkg::STEP_COEF && !r_ph) begin
                    mem_re = cell_ok;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: if (r_clr_addr == AW'(CELLS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_req_type)
                        ctd_pkg::REQ_DEPOSIT: n_state = ST_DEP;
                        ctd_pkg::REQ_READ:    n_state = ST_RD0;
                        ctd_pkg::REQ_CLEAR:   n_state = ST_CLC;
                        default:              n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DEP: begin
                if (r_step == ctd_pkg::STEP_WB && r_cell == 3'd7) n_state = ST_IDLE;
            end
            ST_RD0: n_state = ST_RD1;
            ST_RD1: n_state = ST_RDO;
            ST_RDO: begin
                if ((!r_ovalid || !i_out_stall) && r_n == ctd_pkg::COMP_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
            r_mass     <= ctd_pkg::CFG_RESET;
            r_icv      <= ctd_pkg::CFG_RESET;
            r_cell     <= '0;
            r_step     <= '0;
            r_ph       <= 1'b0;
            r_n        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == ctd_pkg::REG_MASS) r_mass <= i_cfg_data;
                if (i_cfg_index == ctd_pkg::REG_ICV)  r_icv  <= i_cfg_data;
            end
            if (r_state == ST_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (in_acc) begin
                r_cell <= '0;
                r_step <= '0;
                r_ph   <= 1'b0;
                r_n    <= '0;
            end
            if (r_state == ST_DEP) begin
                if (r_step == ctd_pkg::STEP_WB) begin
                    r_cell <= r_cell + 1'b1;
                    r_step <= '0;
                end else if (!r_ph) begin
                    r_ph <= 1'b1;
                end else begin
                    r_ph   <= 1'b0;
                    r_step <= r_step + 1'b1;
                end
            end
            // output register drains when taken
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_RDO && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
                r_n      <= r_n + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_blk    <= i_block_index;
            r_blk_ok <= (32'(i_block_index) < 32'(BLOCKS));
            r_cx     <= CW'(i_cell_x) + CW'(GHOST);
            r_cy     <= CW'(i_cell_y) + CW'(GHOST);
            r_cz     <= CW'(i_cell_z) + CW'(GHOST);
            r_fx     <= (i_frac_x > ctd_pkg::ONE_Q16) ? ctd_pkg::ONE_Q16 : i_frac_x;
            r_fy     <= (i_frac_y > ctd_pkg::ONE_Q16) ? ctd_pkg::ONE_Q16 : i_frac_y;
            r_fz     <= (i_frac_z > ctd_pkg::ONE_Q16) ? ctd_pkg::ONE_Q16 : i_frac_z;
            r_f[0]   <= i_u_dot_normal;
            r_f[1]   <= i_vel_x;
            r_f[2]   <= i_vel_y;
            r_f[3]   <= i_vel_z;
        end
        if (r_state == ST_DEP && r_ph) begin
            case (r_step) inside
                ctd_pkg::STEP_COEF: begin
                    r_coef <= mul_sat[30:0];
                    // row read issued in the previous cycle
                    for (int c = 0; c < ctd_pkg::NCOMP; c++) begin
                        r_row[c] <= r_rdata[c*32 +: 32];
                    end
                end
                ctd_pkg::STEP_SXY: r_m  <= mul_shr[16:0];
                ctd_pkg::STEP_SZ:  r_w  <= mul_shr[16:0];
                ctd_pkg::STEP_CW:  r_cw <= mul_shr[30:0];
                [ctd_pkg::STEP_T0:ctd_pkg::STEP_T3]: r_t[t_idx] <= mul_sat;
                [ctd_pkg::STEP_TERM0:ctd_pkg::STEP_TERM12]: r_row[tn] <= acc_sat;
                default: ;
            endcase
        end
        if (r_state == ST_RD1) begin
            // cells outside the store or block read as zero
            for (int c = 0; c < ctd_pkg::NCOMP; c++) begin
                r_row[c] <= cell_ok ? r_rdata[c*32 +: 32] : 32'sd0;
            end
        end
        if (r_state == ST_RDO && (!r_ovalid || !i_out_stall)) begin
            r_ocomp <= r_n;
            r_oval  <= r_row[r_n];
            r_olast <= (r_n == ctd_pkg::COMP_LAST);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_component = r_ocomp;
    assign o_value     = r_oval;
    assign o_last      = r_olast;

    // reads never overlap a store write
    `CTD_ASSERT(a_rd_no_write, i_clk, i_rst_n,
        (r_state == ST_RD1 || r_state == ST_RDO) |-> !mem_we)
    // a result item only follows the read emit state
    `CTD_ASSERT(a_out_from_read, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_state) == ST_RDO)
    // last flag marks the final component
    `CTD_ASSERT(a_last_comp, i_clk, i_rst_n,
        (o_out_valid && o_last) |-> (o_component == ctd_pkg::COMP_LAST))
    // deposit writes back only at the end of a cell
    `CTD_ASSERT(a_dep_wb, i_clk, i_rst_n,
        (mem_we && r_state == ST_DEP) |-> (r_step == ctd_pkg::STEP_WB))
    // no request is taken during the clearing sweep
    `CTD_ASSERT_ALWAYS(a_clr_stall, i_clk, (r_state == ST_CLR) |-> o_in_stall)

endmodule

FILE: sim/tb_cic_tensor_deposit.sv
`timescale 1ns / 100ps

module tb_cic_tensor_deposit;
    import ctd_pkg::*;

    localparam int EXT        = DEF_CELLS_PER_SIDE + 2 * DEF_GHOST;
    localparam int IDLE_WAIT  = 400;    // outlasts a deposit inside the block
    localparam int STALL_HOLD = 600;    // long receiver hold-off
    localparam int WD_LIMIT   = 20000;  // covers the reset sweep and the hold-off
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // one request item
    typedef struct {
        logic [1:0]         req;
        logic [1:0]         blk;
        logic signed [3:0]  cx, cy, cz;
        logic [16:0]        fx, fy, fz;
        logic signed [31:0] un, vx, vy, vz;
    } cell_req_t;

    // one component item of a read
    typedef struct {
        logic [3:0]         comp;
        logic signed [31:0] value;
        logic               last;
    } comp_item_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [3:0] o_component;
    logic signed [31:0] o_value;
    logic o_last;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = REG_MASS;
    logic [30:0] i_cfg_data = '0;

    cell_req_t cur_req = '{REQ_DEPOSIT, 2'd0, 4'sd0, 4'sd0, 4'sd0, 17'd0, 17'd0, 17'd0,
                           32'sd0, 32'sd0, 32'sd0, 32'sd0};

    cell_req_t  pending_reqs[$];
    comp_item_t expected_comps[$];

    // shadow of the accumulator store and of the two registers
    logic signed [31:0] cell_store [4][EXT][EXT][EXT][NCOMP];
    logic [30:0] mass_q16 = CFG_RESET;
    logic [30:0] icv_q16  = CFG_RESET;

    int n_sent = 0, n_taken = 0, n_comps = 0, n_errors = 0;
    int n_deposits = 0, n_reads = 0, n_clears = 0;
    int burst_left = 4, gap_left = 0;
    int hold_left = 0, stall_mode = 0, stall_tick = 0, quiet_cycles = 0;
    bit hold_done = 0;

    always #4 i_clk = ~i_clk;

    cic_tensor_deposit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(cur_req.req), .i_block_index(cur_req.blk),
        .i_cell_x(cur_req.cx), .i_cell_y(cur_req.cy), .i_cell_z(cur_req.cz),
        .i_frac_x(cur_req.fx), .i_frac_y(cur_req.fy), .i_frac_z(cur_req.fz),
        .i_u_dot_normal(cur_req.un),
        .i_vel_x(cur_req.vx), .i_vel_y(cur_req.vy), .i_vel_z(cur_req.vz),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_component(o_component), .o_value(o_value), .o_last(o_last),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // two truncating q16 products, each saturated
    function automatic longint tensor_term(input longint cw, input longint p,
                                           input longint q);
        longint t;
        t = sat32((cw * p) >>> 16);
        return sat32((t * q) >>> 16);
    endfunction

    function automatic bit in_store(input int idx);
        return idx >= 0 && idx < EXT;
    endfunction

    // scatter one particle over its 2x2x2 neighborhood
    task automatic deposit_particle(input cell_req_t r);
        longint coef, w, cw, un;
        longint fr[3], vel[3], s[3][2];
        int x, y, z;
        coef = (longint'(mass_q16) * longint'(icv_q16)) >>> 16;
        if (coef > 64'sd2147483647) coef = 64'sd2147483647;
        fr[0] = r.fx; fr[1] = r.fy; fr[2] = r.fz;
        vel[0] = r.vx; vel[1] = r.vy; vel[2] = r.vz;
        un = r.un;
        for (int a = 0; a < 3; a++) begin
            if (fr[a] > 65536) fr[a] = 65536;   // fraction above one clamps
            s[a][0] = 65536 - fr[a];
            s[a][1] = fr[a];
        end
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 2; k++) begin
                    x = int'(r.cx) + DEF_GHOST + i;
                    y = int'(r.cy) + DEF_GHOST + j;
                    z = int'(r.cz) + DEF_GHOST + k;
                    if (in_store(x) && in_store(y) && in_store(z)) begin
                        w  = (((s[0][i] * s[1][j]) >>> 16) * s[2][k]) >>> 16;
                        cw = (coef * w) >>> 16;
                        cell_store[r.blk][z][y][x][0] = sat32(
                            longint'(cell_store[r.blk][z][y][x][0]) +
                            tensor_term(cw, un, un));
                        for (int a = 0; a < 3; a++) begin
                            cell_store[r.blk][z][y][x][1+a] = sat32(
                                longint'(cell_store[r.blk][z][y][x][1+a]) -
                                tensor_term(cw, vel[a], un));
                            for (int b = 0; b < 3; b++)
                                cell_store[r.blk][z][y][x][4+3*a+b] = sat32(
                                    longint'(cell_store[r.blk][z][y][x][4+3*a+b]) +
                                    tensor_term(cw, vel[a], vel[b]));
                        end
                    end
                end
    endtask

    // update the shadow store and queue what a read will return
    task automatic apply_request(input cell_req_t r);
        int x, y, z;
        bit ok;
        comp_item_t e;
        x = int'(r.cx) + DEF_GHOST;
        y = int'(r.cy) + DEF_GHOST;
        z = int'(r.cz) + DEF_GHOST;
        ok = in_store(x) && in_store(y) && in_store(z) && int'(r.blk) < DEF_BLOCKS;
        case (r.req)
            REQ_DEPOSIT: begin
                n_deposits++;
                if (int'(r.blk) < DEF_BLOCKS) deposit_particle(r);
            end
            REQ_READ: begin
                n_reads++;
                for (int n = 0; n < NCOMP; n++) begin
                    e.comp  = 4'(n);
                    e.value = ok ? cell_store[r.blk][z][y][x][n] : 32'sd0;
                    e.last  = (4'(n) == COMP_LAST);
                    expected_comps.push_back(e);
                end
            end
            REQ_CLEAR: begin
                n_clears++;
                if (ok)
                    for (int n = 0; n < NCOMP; n++) cell_store[r.blk][z][y][x][n] = '0;
            end
            default: ;  // unused type is ignored
        endcase
    endtask

    function automatic cell_req_t make_req(input logic [1:0] req, input logic [1:0] blk,
            input int cx, input int cy, input int cz, input int fx, input int fy,
            input int fz, input int un, input int vx, input int vy, input int vz);
        cell_req_t r;
        r.req = req; r.blk = blk;
        r.cx = 4'(cx); r.cy = 4'(cy); r.cz = 4'(cz);
        r.fx = 17'(fx); r.fy = 17'(fy); r.fz = 17'(fz);
        r.un = un; r.vx = vx; r.vy = vy; r.vz = vz;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_vel();
        if ($urandom_range(0, 9) < 7)
            return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
        return $urandom;
    endfunction

    function automatic logic signed [3:0] rand_cell();
        // most indices sit near the origin so items pile onto the same cells
        if ($urandom_range(0, 4) != 0) return 4'($signed($urandom_range(0, 3)) - 1);
        return 4'($urandom);
    endfunction

    function automatic logic [16:0] rand_frac();
        if ($urandom_range(0, 7) == 0) return 17'($urandom);
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic cell_req_t rand_req();
        cell_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.req = pick < 50 ? REQ_DEPOSIT : pick < 86 ? REQ_READ :
                pick < 96 ? REQ_CLEAR : REQ_UNUSED;
        r.blk = 2'($urandom);
        r.cx = rand_cell(); r.cy = rand_cell(); r.cz = rand_cell();
        r.fx = rand_frac(); r.fy = rand_frac(); r.fz = rand_frac();
        r.un = rand_vel(); r.vx = rand_vel(); r.vy = rand_vel(); r.vz = rand_vel();
        return r;
    endfunction

    // ---------------- request driver ----------------
    // acceptance is sampled at the rising edge and fed to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            apply_request(cur_req);
            n_taken <= n_taken + 1;
        end
    end

    // new items are offered at the falling edge, in bursts with gaps
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && n_taken != n_sent)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                n_sent <= n_sent + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    // a zero gap now and then gives long unbroken stretches
                    gap_left <= $urandom_range(0, 2) == 0 ? 0 :
                                $urandom_range(0, 5) == 0 ? $urandom_range(20, 60) :
                                $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------- result receiver ----------------
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 63) stall_mode <= $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_comps >= 20) begin
            // long hold-off: reads back up and the input side stalls
            hold_done <= 1'b1;
            hold_left <= STALL_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // compare each accepted component with the oldest expectation
    always @(posedge i_clk) begin
        comp_item_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_comps <= n_comps + 1;
            if (expected_comps.size() == 0) begin
                if (n_errors < 10)
                    $display("unexpected item: comp %0d value %0d last %0d",
                             o_component, o_value, o_last);
                n_errors <= n_errors + 1;
            end else begin
                e = expected_comps.pop_front();
                if (o_component !== e.comp || o_value !== e.value || o_last !== e.last) begin
                    if (n_errors < 10)
                        $display("mismatch: exp comp %0d value %0d last %0d, got %0d %0d %0d",
                                 e.comp, e.value, e.last, o_component, o_value, o_last);
                    n_errors <= n_errors + 1;
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WD_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // register write, one cycle, driven at the falling edge
    task automatic write_reg(input logic idx, input logic [30:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx == REG_MASS) mass_q16 = data; else icv_q16 = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every item is taken, the block is back in idle and reads have drained
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_reqs.size() != 0 || n_taken != n_sent ||
                   expected_comps.size() != 0 || o_in_stall);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) pending_reqs.push_back(rand_req());
    endtask

    initial begin
        for (int b = 0; b < 4; b++)
            for (int z = 0; z < EXT; z++)
                for (int y = 0; y < EXT; y++)
                    for (int x = 0; x < EXT; x++)
                        for (int n = 0; n < NCOMP; n++) cell_store[b][z][y][x][n] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unit mass and volume, directed corners first
        write_reg(REG_MASS, CFG_RESET);
        write_reg(REG_ICV, CFG_RESET);
        pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_DEPOSIT, 0, 0, 0, 0, 0, 0, 0,
                                        65536, 65536, -65536, 32768));
        pending_reqs.push_back(make_req(REQ_DEPOSIT, 0, 0, 0, 0, 65536, 65536, 65536,
                                        -131072, 1, -1, 65536));
        // fraction above one clamps
        pending_reqs.push_back(make_req(REQ_DEPOSIT, 0, 0, 0, 0, 131071, 100000, 70000,
                                        65536, 65536, 65536, 65536));
        pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_READ, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        // ghost side and the top corner of the last block
        pending_reqs.push_back(make_req(REQ_DEPOSIT, 3, -1, -1, -1, 32768, 16384, 49152,
                                        32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, -5));
        pending_reqs.push_back(make_req(REQ_DEPOSIT, 3, 7, 7, 7, 30000, 40000, 50000,
                                        32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
        pending_reqs.push_back(make_req(REQ_READ, 3, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_READ, 3, 8 - 1, 7, 7, 0, 0, 0, 0, 0, 0, 0));
        // deposit partly and wholly outside the store, read outside it
        pending_reqs.push_back(make_req(REQ_DEPOSIT, 1, -3, 0, 0, 65536, 0, 0,
                                        65536, 65536, 65536, 65536));
        pending_reqs.push_back(make_req(REQ_DEPOSIT, 1, -8, -8, -8, 1000, 2000, 3000,
                                        65536, 65536, 65536, 65536));
        pending_reqs.push_back(make_req(REQ_READ, 1, -2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_READ, 1, -8, -8, -8, 0, 0, 0, 0, 0, 0, 0));
        // clear, clear outside, unused type, read back
        pending_reqs.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_CLEAR, 2, -8, 3, 3, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_UNUSED, 0, 1, 1, 1, 0, 0, 0, 9, 9, 9, 9));
        pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_READ, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_random(70);
        wait_idle();

        // largest registers: coefficient saturates, terms saturate
        write_reg(REG_MASS, 31'h7FFFFFFF);
        write_reg(REG_ICV, 31'h7FFFFFFF);
        for (int n = 0; n < 3; n++)
            pending_reqs.push_back(make_req(REQ_DEPOSIT, 2, 0, 0, 0, 0, 0, 0,
                                            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0));
        pending_reqs.push_back(make_req(REQ_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_random(50);
        wait_idle();

        // zero mass: deposits add nothing
        write_reg(REG_MASS, '0);
        write_reg(REG_ICV, 31'($urandom));
        queue_random(40);
        wait_idle();

        // random moderate settings
        write_reg(REG_MASS, 31'($urandom_range(0, 32'h3FFFF)));
        write_reg(REG_ICV, 31'($urandom_range(0, 32'h3FFFF)));
        queue_random(70);
        wait_idle();

        $display("covered %0d deposits, %0d reads, %0d clears, %0d components checked",
                 n_deposits, n_reads, n_clears, n_comps);
        $display("four register settings including both extremes, %0d mismatches", n_errors);
        if (n_errors == 0 && expected_comps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ctd_pkg.sv
rtl/ctd_mul.sv
rtl/cic_tensor_deposit.sv
sim/tb_cic_tensor_deposit.sv
